[rtl/ps2_mouse_packet_decoder_defines.svh]
// Assertion macros shared by the checker of the PS/2 mouse packet decoder.
// Depends on nothing; included by the checker file only.
`ifndef PS2_MOUSE_PACKET_DECODER_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_DEFINES_SVH

// Condition that must hold in every cycle outside reset.
`define PS2MD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define PS2MD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define PS2MD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ps2md_pkg.sv]
`timescale 1ns / 1ps
// Types and constants of the PS/2 mouse packet decoder.
// Depends on nothing; used by every other file of the block but the defines header.
package ps2md_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] EV_MOVE       = 3'd0;
    localparam logic [2:0] EV_SCROLL     = 3'd1;
    localparam logic [2:0] EV_LEFT_DOWN  = 3'd2;
    localparam logic [2:0] EV_LEFT_UP    = 3'd3;
    localparam logic [2:0] EV_RIGHT_DOWN = 3'd4;
    localparam logic [2:0] EV_RIGHT_UP   = 3'd5;

    localparam logic [1:0] REG_WHEEL_MODE    = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd1024;
    localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd768;

    localparam int unsigned SYNC_BIT    = 3;
    localparam int unsigned X_SIGN_BIT  = 4;
    localparam int unsigned Y_SIGN_BIT  = 5;
    localparam int unsigned X_OVFL_BIT  = 6;
    localparam int unsigned Y_OVFL_BIT  = 7;

    typedef struct packed {
        logic [1:0]  buttons;
        logic [1:0]  prev_buttons;
        logic [7:0]  wheel;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } cmd_t;

endpackage

[rtl/ps2md_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: mouse bytes in, decoded events out.
// Depends on ps2md_pkg.
interface ps2md_byte_if import ps2md_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface ps2md_event_if import ps2md_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        event_kind;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic signed [7:0] scroll_amount;
    logic              last;

    modport source (output valid, output event_kind, output pos_x, output pos_y,
                    output scroll_amount, output last, input ready);
    modport sink (input valid, input event_kind, input pos_x, input pos_y,
                  input scroll_amount, input last, output ready);
endinterface

[rtl/ps2_mouse_packet_decoder.sv]
`timescale 1ns / 1ps
// Top level of the PS/2 mouse packet decoder with wheel support.
// Depends on ps2md_pkg, ps2md_if, ps2md_front, ps2md_queue and ps2md_back.
//
//   Channel   Dir   Beat contents
//   mouse     in    data_byte
//   events    out   event_kind, pos_x, pos_y, scroll_amount, last
//   cfg_*     in    wheel_mode, screen_width, screen_height writes
//
// A byte is taken whenever the command queue has room.
// A packet without overflow yields one to four events, one per unstalled cycle.
// The queue holds QUEUE_DEPTH packets, so bytes keep flowing while events drain.
// Reset clears framing, cursor, button memory and the queue; no clearing pass.
module ps2_mouse_packet_decoder import ps2md_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write_en,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    ps2md_byte_if.sink     mouse,
    ps2md_event_if.source  events
);

    logic push, full, pop, not_empty;
    cmd_t push_data, pop_data;

    ps2md_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_valid   (mouse.valid),
        .byte_data    (mouse.data_byte),
        .byte_ready   (mouse.ready),
        .push         (push),
        .push_data    (push_data),
        .queue_full   (full)
    );

    ps2md_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    ps2md_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_data   (pop_data),
        .not_empty  (not_empty),
        .out_valid  (events.valid),
        .out_ready  (events.ready),
        .out_kind   (events.event_kind),
        .out_pos_x  (events.pos_x),
        .out_pos_y  (events.pos_y),
        .out_scroll (events.scroll_amount),
        .out_last   (events.last)
    );

endmodule

[rtl/ps2md_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, packet framing and cursor update.
// Depends on ps2md_pkg; feeds packet commands to ps2md_queue.
module ps2md_front import ps2md_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        byte_valid,
    input  logic [7:0]  byte_data,
    output logic        byte_ready,
    output logic        push,
    output cmd_t        push_data,
    input  logic        queue_full
);

    logic        wheel_mode_reg;
    logic [15:0] screen_width_reg;
    logic [15:0] screen_height_reg;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [7:0]  pkt0_reg, pkt1_reg, pkt2_reg;
    logic [1:0]  prev_buttons_reg;
    logic [15:0] cursor_x_reg, cursor_y_reg;

    logic        accept;
    logic        is_final;
    logic [7:0]  y_byte;
    logic [7:0]  wheel_byte;
    logic        overflow;
    logic [17:0] dx_ext, dy_ext, sum_x, sum_y;
    logic [15:0] new_x, new_y;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign is_final   = (byte_index_reg != 2'd0)
                        && (byte_index_reg >= {1'b1, wheel_mode_reg});
    assign y_byte     = wheel_mode_reg ? pkt2_reg : byte_data;
    assign wheel_byte = wheel_mode_reg ? byte_data : 8'd0;
    assign overflow   = pkt0_reg[X_OVFL_BIT] || pkt0_reg[Y_OVFL_BIT];

    assign dx_ext = {{10{pkt0_reg[X_SIGN_BIT]}}, pkt1_reg};
    assign dy_ext = {{10{pkt0_reg[Y_SIGN_BIT]}}, y_byte};
    assign sum_x  = {2'b00, cursor_x_reg} + dx_ext;
    assign sum_y  = {2'b00, cursor_y_reg} - dy_ext;

    always_comb
    begin
        if (sum_x[17])
            new_x = 16'd0;
        else if (sum_x[16:0] > {1'b0, screen_width_reg})
            new_x = screen_width_reg;
        else
            new_x = sum_x[15:0];
        if (sum_y[17])
            new_y = 16'd0;
        else if (sum_y[16:0] > {1'b0, screen_height_reg})
            new_y = screen_height_reg;
        else
            new_y = sum_y[15:0];
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (byte_index_reg == 2'd0)
        begin
            if (byte_data[SYNC_BIT])
                byte_index_next = 2'd1;
        end
        else if (is_final)
            byte_index_next = 2'd0;
        else
            byte_index_next = byte_index_reg + 2'd1;
    end

    assign push                   = accept && is_final && !overflow;
    assign push_data.buttons      = pkt0_reg[1:0];
    assign push_data.prev_buttons = prev_buttons_reg;
    assign push_data.wheel        = wheel_byte;
    assign push_data.pos_x        = new_x;
    assign push_data.pos_y        = new_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg    <= 1'b0;
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            byte_index_reg    <= 2'd0;
            prev_buttons_reg  <= 2'd0;
            cursor_x_reg      <= 16'd0;
            cursor_y_reg      <= 16'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_WHEEL_MODE:    wheel_mode_reg    <= cfg_data[0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
                byte_index_reg <= byte_index_next;
            if (push)
            begin
                prev_buttons_reg <= pkt0_reg[1:0];
                cursor_x_reg     <= new_x;
                cursor_y_reg     <= new_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_final)
        begin
            if (byte_index_reg == 2'd0)
                pkt0_reg <= byte_data;
            else if (byte_index_reg == 2'd1)
                pkt1_reg <= byte_data;
            else
                pkt2_reg <= byte_data;
        end
    end

endmodule

[rtl/ps2md_queue.sv]
`timescale 1ns / 1ps
// Short queue of packet commands between the front and back ends.
// Depends on ps2md_pkg for the command type.
module ps2md_queue import ps2md_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic not_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/ps2md_back.sv]
`timescale 1ns / 1ps
// Back end: expands each packet command into its events, one per cycle unless out_ready stalls.
// Depends on ps2md_pkg; takes commands from ps2md_queue.
module ps2md_back import ps2md_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    output logic              pop,
    input  cmd_t              pop_data,
    input  logic              not_empty,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_kind,
    output logic [15:0]       out_pos_x,
    output logic [15:0]       out_pos_y,
    output logic signed [7:0] out_scroll,
    output logic              out_last
);

    // Pending events: bit 0 scroll, bit 1 move, bit 2 left, bit 3 right.
    logic [3:0]        mask_reg, mask_next;
    cmd_t              cmd_reg;
    logic              out_valid_reg;
    logic [2:0]        kind_reg;
    logic [15:0]       pos_x_reg, pos_y_reg;
    logic signed [7:0] scroll_reg;
    logic              last_reg;

    logic              advance;
    logic [3:0]        pick, mask_after, load_mask;
    logic [2:0]        kind;
    logic [7:0]        scroll;

    assign advance    = (mask_reg != 4'd0) && (!out_valid_reg || out_ready);
    assign pick       = mask_reg & (~mask_reg + 4'd1);
    assign mask_after = mask_reg & ~pick;
    assign pop        = not_empty && ((mask_reg == 4'd0) || (advance && mask_after == 4'd0));

    assign load_mask = {pop_data.buttons[1] | pop_data.prev_buttons[1],
                        pop_data.buttons[0] | pop_data.prev_buttons[0],
                        1'b1,
                        pop_data.wheel != 8'd0};

    always_comb
    begin
        scroll = 8'd0;
        if (mask_reg[0])
        begin
            kind   = EV_SCROLL;
            scroll = cmd_reg.wheel;
        end
        else if (mask_reg[1])
            kind = EV_MOVE;
        else if (mask_reg[2])
            kind = cmd_reg.buttons[0] ? EV_LEFT_DOWN : EV_LEFT_UP;
        else
            kind = cmd_reg.buttons[1] ? EV_RIGHT_DOWN : EV_RIGHT_UP;
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (advance)
            mask_next = mask_after;
        if (pop)
            mask_next = load_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= pop_data;
        if (advance)
        begin
            kind_reg   <= kind;
            pos_x_reg  <= cmd_reg.pos_x;
            pos_y_reg  <= cmd_reg.pos_y;
            scroll_reg <= scroll;
            last_reg   <= (mask_after == 4'd0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_pos_x  = pos_x_reg;
    assign out_pos_y  = pos_y_reg;
    assign out_scroll = scroll_reg;
    assign out_last   = last_reg;

endmodule

[rtl/ps2md_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the PS/2 mouse packet decoder, bound to the top level.
// Depends on ps2md_pkg and ps2_mouse_packet_decoder_defines.svh.
`include "ps2_mouse_packet_decoder_defines.svh"

module ps2md_checker import ps2md_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              ev_valid,
    input logic              ev_ready,
    input logic [2:0]        ev_kind,
    input logic [15:0]       ev_pos_x,
    input logic [15:0]       ev_pos_y,
    input logic signed [7:0] ev_scroll,
    input logic              ev_last
);

    `PS2MD_ASSERT_NEXT(a_valid_held, clk, rst_n, ev_valid && !ev_ready, ev_valid,
        "event beat dropped while stalled")
    `PS2MD_ASSERT_NEXT(a_payload_held, clk, rst_n, ev_valid && !ev_ready,
        $stable(ev_kind) && $stable(ev_pos_x) && $stable(ev_pos_y)
        && $stable(ev_scroll) && $stable(ev_last),
        "event beat changed while stalled")
    `PS2MD_ASSERT_ALWAYS(a_kind_range, clk, rst_n, !ev_valid || ev_kind <= EV_RIGHT_UP,
        "event kind out of range")
    `PS2MD_ASSERT_IMPL(a_scroll_only, clk, rst_n, ev_valid,
        (ev_kind == EV_SCROLL) == (ev_scroll != 8'sd0),
        "scroll amount does not match the event kind")
    `PS2MD_ASSERT_IMPL(a_scroll_not_last, clk, rst_n, ev_valid && ev_kind == EV_SCROLL,
        !ev_last, "scroll event marked as the last of its packet")

endmodule

bind ps2_mouse_packet_decoder ps2md_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (events.valid),
    .ev_ready  (events.ready),
    .ev_kind   (events.event_kind),
    .ev_pos_x  (events.pos_x),
    .ev_pos_y  (events.pos_y),
    .ev_scroll (events.scroll_amount),
    .ev_last   (events.last)
);
